[sv/serial_response_deframer_macros.svh]
// Assertion macros for the serial response deframer.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef SERIAL_RESPONSE_DEFRAMER_MACROS_SVH
`define SERIAL_RESPONSE_DEFRAMER_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define SRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/srd_pkg.sv]
// Shared types and constants for the serial response deframer.
// No dependencies; imported by every module of the block.
package srd_pkg;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'd170;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'd85;

  typedef enum logic {
    REG_SYNC_FIRST  = 1'b0,
    REG_SYNC_SECOND = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_OK       = 2'd1,
    KIND_BADHDR   = 2'd2,
    KIND_MISMATCH = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_CHECK   = 3'b100
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] resp_code;
    logic [7:0] frame_len;
    logic       last;
  } result_t;

endpackage

[sv/srd_parser.sv]
// Frame parser: header/payload/checksum state and per-byte result decode.
// Depends on srd_pkg. State advances on each accepted byte.
module srd_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      sync_first,
  input  logic [7:0]      sync_second,
  input  logic            in_fire,
  input  logic [7:0]      rx_byte,
  output logic            res_valid,
  output srd_pkg::result_t res
);
  import srd_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] header_count, header_count_next;
  logic       header_bad, header_bad_next;
  logic [7:0] code_reg, code_reg_next;
  logic [7:0] len_reg, len_reg_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] count_inc;

  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    header_bad_next    = header_bad;
    code_reg_next      = code_reg;
    len_reg_next       = len_reg;
    running_xor_next   = running_xor;
    payload_count_next = payload_count;
    res_valid          = 1'b0;
    res.kind           = KIND_DATA;
    res.data_byte      = 8'd0;
    res.byte_index     = 8'd0;
    res.resp_code      = code_reg;
    res.frame_len      = len_reg;
    res.last           = 1'b0;

    case (phase)
      PH_PAYLOAD: begin
        res_valid          = 1'b1;
        res.data_byte      = rx_byte;
        res.byte_index     = payload_count;
        running_xor_next   = running_xor ^ rx_byte;
        payload_count_next = count_inc;
        if (count_inc == len_reg) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        res_valid          = 1'b1;
        res.kind           = (running_xor == rx_byte) ? KIND_OK : KIND_MISMATCH;
        res.last           = 1'b1;
        phase_next         = PH_HEADER;
        header_count_next  = 2'd0;
        header_bad_next    = 1'b0;
        running_xor_next   = 8'd0;
        payload_count_next = 8'd0;
      end
      default: begin
        // header phase; the unused phase codes land here too
        case (header_count)
          2'd0: begin
            header_bad_next   = (rx_byte != sync_first);
            header_count_next = 2'd1;
            phase_next        = PH_HEADER;
          end
          2'd1: begin
            if (rx_byte != sync_second) begin
              header_bad_next = 1'b1;
            end
            header_count_next = 2'd2;
          end
          2'd2: begin
            code_reg_next     = rx_byte;
            header_count_next = 2'd3;
          end
          default: begin
            len_reg_next = rx_byte;
            if (header_bad) begin
              res_valid          = 1'b1;
              res.kind           = KIND_BADHDR;
              res.frame_len      = rx_byte;
              res.last           = 1'b1;
              phase_next         = PH_HEADER;
              header_count_next  = 2'd0;
              header_bad_next    = 1'b0;
              running_xor_next   = 8'd0;
              payload_count_next = 8'd0;
            end else begin
              running_xor_next   = code_reg ^ rx_byte;
              payload_count_next = 8'd0;
              header_count_next  = 2'd0;
              phase_next         = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      header_count  <= 2'd0;
      header_bad    <= 1'b0;
      code_reg      <= 8'd0;
      len_reg       <= 8'd0;
      running_xor   <= 8'd0;
      payload_count <= 8'd0;
    end else if (in_fire) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      header_bad    <= header_bad_next;
      code_reg      <= code_reg_next;
      len_reg       <= len_reg_next;
      running_xor   <= running_xor_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

[sv/srd_out_buf.sv]
// Two-entry result buffer: output register plus skid entry.
// Depends on srd_pkg for the result item type.
module srd_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srd_pkg::result_t din,
  output logic            has_room,
  output logic            out_valid,
  input  logic            out_ready,
  output srd_pkg::result_t dout
);
  import srd_pkg::*;

  result_t    ent0, ent1;
  logic [1:0] count, count_next;
  logic       pop;

  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign pop       = out_valid && out_ready;
  assign dout      = ent0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // payload entries carry no reset
  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      ent0 <= din;
    end else if (pop && (count == 2'd2)) begin
      ent0 <= ent1;
    end
    if (push && (count == 2'd1) && !pop) begin
      ent1 <= din;
    end
  end

endmodule

[sv/serial_response_deframer.sv]
// Serial response deframer, top level.
// Depends on srd_pkg, srd_parser, srd_out_buf and the assertion macro header.
//
// Input: one received byte per item on in_valid/in_ready/rx_byte.
// Frames are sync, sync, code, length, payload bytes, XOR checksum.
// Output: at most one item per input byte on out_valid/out_ready:
// each payload byte with its index, a bad-header status on the fourth
// header byte when a sync byte mismatched, and ok/mismatch on the checksum.
// Each result is registered in the result buffer before it is output.
// Throughput: one byte per cycle while the buffer has room; the per-byte
// decode is a compare and an XOR between input port and result buffer.
// Stall: results sit in a two-entry buffer; in_ready drops only when both
// entries are full, so one stalled result does not block the input.
// Reset: rst (synchronous) clears the parser to the header phase, empties
// the buffer and loads the sync registers with 0xAA and 0x55.
// Config: cfg_we writes cfg_data into the register at cfg_index; write only
// while the block is idle.
module serial_response_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index,
  output logic [7:0] resp_code,
  output logic [7:0] frame_len,
  output logic       last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import srd_pkg::*;

  `include "serial_response_deframer_macros.svh"

  logic [7:0] sync_first, sync_second;
  logic       in_fire;
  logic       res_valid;
  result_t    res, out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;

  srd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .sync_first (sync_first),
    .sync_second(sync_second),
    .in_fire    (in_fire),
    .rx_byte    (rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  srd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (in_fire && res_valid),
    .din      (res),
    .has_room (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dout     (out_item)
  );

  assign kind       = out_item.kind;
  assign data_byte  = out_item.data_byte;
  assign byte_index = out_item.byte_index;
  assign resp_code  = out_item.resp_code;
  assign frame_len  = out_item.frame_len;
  assign last       = out_item.last;

  `SRD_ASSERT_IMP(a_status_ends_frame, out_valid && (out_item.kind != KIND_DATA), out_item.last, "status item without last")
  `SRD_ASSERT_IMP(a_status_zero_fields, out_valid && out_item.last, (out_item.data_byte == 8'd0) && (out_item.byte_index == 8'd0), "status item carries payload fields")
  `SRD_ASSERT_IMP(a_full_has_output, !in_ready, out_valid, "input blocked with empty buffer")
  `SRD_ASSERT_NEXT(a_result_lands, in_fire && res_valid, out_valid, "accepted result not buffered")

endmodule
